// ===== rtl/q2e_pkg.sv =====
// shared constants, types and the cordic arctangent table for the quaternion to euler block
// no dependencies
package q2e_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS   = 29;
  localparam int FRONT_STAGES = 4;
  localparam int LATENCY      = FRONT_STAGES + SQRT_STEPS + 1 + CORDIC_STEPS + 1;

  localparam int SW = 34;  // products and sums, q4.28 plus growth
  localparam int CW = 36;  // cordic x and y
  localparam int AW = 26;  // angle, 2^-16 degree

  localparam logic signed [SW-1:0] ONE_Q28   = SW'(64'sd268435456);
  localparam logic signed [AW-1:0] DEG90     = AW'(64'sd5898240);
  localparam logic signed [13:0]   PITCH_LIM = 14'sd5760;
  localparam logic signed [14:0]   ANGLE_LIM = 15'sd11520;

  typedef struct packed {
    logic signed [SW-1:0] yn;
    logic signed [SW-1:0] yd;
    logic signed [SW-1:0] rn;
    logic signed [SW-1:0] rd;
    logic signed [29:0]   s;
    logic                 clamped;
  } side_t;

  function automatic logic signed [AW-1:0] atan_entry(input int i);
    logic signed [AW-1:0] r;
    case (i)
      0:       r = AW'(2949120);
      1:       r = AW'(1740967);
      2:       r = AW'(919879);
      3:       r = AW'(466945);
      4:       r = AW'(234379);
      5:       r = AW'(117305);
      6:       r = AW'(58666);
      7:       r = AW'(29335);
      8:       r = AW'(14668);
      9:       r = AW'(7334);
      10:      r = AW'(3667);
      11:      r = AW'(1833);
      12:      r = AW'(917);
      13:      r = AW'(458);
      14:      r = AW'(229);
      15:      r = AW'(115);
      16:      r = AW'(57);
      17:      r = AW'(29);
      18:      r = AW'(14);
      19:      r = AW'(7);
      20:      r = AW'(4);
      21:      r = AW'(2);
      22:      r = AW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/q2e_front.sv =====
// front stages: quaternion products, angle operands, asin clamp, square and radicand
// depends on q2e_pkg
module q2e_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    valid_i,
  input  logic signed [15:0]      w_i,
  input  logic signed [15:0]      x_i,
  input  logic signed [15:0]      y_i,
  input  logic signed [15:0]      z_i,
  output logic                    valid_o,
  output logic [56:0]             rad_o,
  output q2e_pkg::side_t          side_o
);

  logic                 v1_r, v2_r, v3_r, v4_r;
  logic signed [31:0]   wy_r, xz_r, wz_r, yx_r, yy_r, zz_r, xx_r, wx_r, zy_r;
  q2e_pkg::side_t       side2_r, side3_r, side4_r, side2_nxt;
  logic [28:0]          sabs_r, sabs_nxt;
  logic [57:0]          sq_r;
  logic [56:0]          rad_r;
  logic signed [32:0]   sum_yn, sum_yd, sum_rn, sum_rd, sum_s;
  logic signed [q2e_pkg::SW-1:0] s_full;

  always_comb begin
    sum_yn = 33'(wy_r) + 33'(xz_r);
    sum_yd = 33'(yy_r) + 33'(zz_r);
    sum_rn = 33'(wz_r) + 33'(yx_r);
    sum_rd = 33'(xx_r) + 33'(zz_r);
    sum_s  = 33'(wx_r) - 33'(zy_r);
    s_full = {sum_s, 1'b0};
    side2_nxt.yn = {sum_yn, 1'b0};
    side2_nxt.yd = q2e_pkg::ONE_Q28 - {sum_yd, 1'b0};
    side2_nxt.rn = {sum_rn, 1'b0};
    side2_nxt.rd = q2e_pkg::ONE_Q28 - {sum_rd, 1'b0};
    side2_nxt.clamped = 1'b0;
    if (s_full > q2e_pkg::ONE_Q28) begin
      side2_nxt.s = 30'(q2e_pkg::ONE_Q28);
      side2_nxt.clamped = 1'b1;
    end else if (s_full < -q2e_pkg::ONE_Q28) begin
      side2_nxt.s = 30'(-q2e_pkg::ONE_Q28);
      side2_nxt.clamped = 1'b1;
    end else begin
      side2_nxt.s = 30'(s_full);
    end
    if (side2_nxt.s < 0) begin
      sabs_nxt = 29'(-side2_nxt.s);
    end else begin
      sabs_nxt = 29'(side2_nxt.s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    wy_r <= w_i * y_i;
    xz_r <= x_i * z_i;
    wz_r <= w_i * z_i;
    yx_r <= y_i * x_i;
    yy_r <= y_i * y_i;
    zz_r <= z_i * z_i;
    xx_r <= x_i * x_i;
    wx_r <= w_i * x_i;
    zy_r <= z_i * y_i;
    side2_r <= side2_nxt;
    sabs_r  <= sabs_nxt;
    side3_r <= side2_r;
    sq_r    <= sabs_r * sabs_r;
    side4_r <= side3_r;
    rad_r   <= (57'(1) << 56) - 57'(sq_r);
  end

  assign valid_o = v4_r;
  assign rad_o   = rad_r;
  assign side_o  = side4_r;

endmodule

// ===== rtl/q2e_sqrt.sv =====
// pipelined integer square root, one result bit per stage, side data carried along
// depends on q2e_pkg
module q2e_sqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  input  logic [56:0]    rad_i,
  input  q2e_pkg::side_t side_i,
  output logic           valid_o,
  output logic [28:0]    root_o,
  output q2e_pkg::side_t side_o
);

  localparam int N = q2e_pkg::SQRT_STEPS;

  logic           v_r    [N];
  logic [56:0]    n_r    [N];
  logic [56:0]    res_r  [N];
  q2e_pkg::side_t side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [56:0] BIT = 57'(1) << (2 * (N - 1 - k));
    logic           v_src;
    logic [56:0]    n_src, res_src, trial;
    q2e_pkg::side_t side_src;

    if (k == 0) begin : g_first
      assign v_src    = valid_i;
      assign n_src    = rad_i;
      assign res_src  = '0;
      assign side_src = side_i;
    end else begin : g_next
      assign v_src    = v_r[k-1];
      assign n_src    = n_r[k-1];
      assign res_src  = res_r[k-1];
      assign side_src = side_r[k-1];
    end

    assign trial = res_src + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      side_r[k] <= side_src;
      if (n_src >= trial) begin
        n_r[k]   <= n_src - trial;
        res_r[k] <= (res_src >> 1) + BIT;
      end else begin
        n_r[k]   <= n_src;
        res_r[k] <= res_src >> 1;
      end
    end
  end

  assign valid_o = v_r[N-1];
  assign root_o  = 29'(res_r[N-1]);
  assign side_o  = side_r[N-1];

endmodule

// ===== rtl/q2e_cordic.sv =====
// pipelined vectoring cordic atan2 with quadrant pre-rotation, angle in 2^-16 degree
// depends on q2e_pkg
module q2e_cordic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_i,
  input  logic                          tag_i,
  input  logic signed [q2e_pkg::SW-1:0] num_i,
  input  logic signed [q2e_pkg::SW-1:0] den_i,
  output logic                          valid_o,
  output logic                          tag_o,
  output logic signed [q2e_pkg::AW-1:0] angle_o
);

  localparam int N  = q2e_pkg::CORDIC_STEPS;
  localparam int CW = q2e_pkg::CW;
  localparam int AW = q2e_pkg::AW;

  logic                 v_r    [N+1];
  logic                 tag_r  [N+1];
  logic                 zero_r [N+1];
  logic signed [CW-1:0] x_r    [N+1];
  logic signed [CW-1:0] y_r    [N+1];
  logic signed [AW-1:0] z_r    [N+1];
  logic signed [CW-1:0] xe, ye;

  assign xe = CW'(den_i);
  assign ye = CW'(num_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0]  <= tag_i;
    zero_r[0] <= (xe == '0) && (ye == '0);
    if (xe < 0) begin
      if (ye >= 0) begin
        x_r[0] <= ye;
        y_r[0] <= -xe;
        z_r[0] <= q2e_pkg::DEG90;
      end else begin
        x_r[0] <= -ye;
        y_r[0] <= xe;
        z_r[0] <= -q2e_pkg::DEG90;
      end
    end else begin
      x_r[0] <= xe;
      y_r[0] <= ye;
      z_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [AW-1:0] ATAN = q2e_pkg::atan_entry(i);
    logic signed [CW-1:0] xs, ys;

    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      tag_r[i+1]  <= tag_r[i];
      zero_r[i+1] <= zero_r[i];
      if (y_r[i] > 0) begin
        x_r[i+1] <= x_r[i] + ys;
        y_r[i+1] <= y_r[i] - xs;
        z_r[i+1] <= z_r[i] + ATAN;
      end else begin
        x_r[i+1] <= x_r[i] - ys;
        y_r[i+1] <= y_r[i] + xs;
        z_r[i+1] <= z_r[i] - ATAN;
      end
    end
  end

  assign valid_o = v_r[N];
  assign tag_o   = tag_r[N];
  assign angle_o = zero_r[N] ? '0 : z_r[N];

endmodule

// ===== rtl/quaternion_to_euler_angles.sv =====
// quaternion to euler angles (yaw, pitch, roll) in 1/64 degree
// pipeline: front stages, square root stages, cordic pre-rotation, cordic steps, output register
// throughput: one quaternion per cycle, busy is never raised; the receiver cannot stall
// reset clears only the valid bits of every stage, items in flight are dropped
// depends on q2e_pkg, q2e_front, q2e_sqrt, q2e_cordic
module quaternion_to_euler_angles (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  output logic               out_valid,
  output logic signed [13:0] out_pitch_deg,
  output logic signed [14:0] out_yaw_deg,
  output logic signed [14:0] out_roll_deg,
  output logic               out_asin_clamped
);

  localparam int AW = q2e_pkg::AW;

  logic                 f_valid, s_valid, py_valid, pp_valid, pr_valid;
  logic [56:0]          f_rad;
  q2e_pkg::side_t       f_side, s_side;
  logic [28:0]          s_root;
  logic                 p_tag, y_tag, r_tag;
  logic signed [AW-1:0] yaw_a, pitch_a, roll_a;
  logic                 out_valid_r, clamped_r;
  logic signed [13:0]   pitch_r, pitch_nxt;
  logic signed [14:0]   yaw_r, yaw_nxt, roll_r, roll_nxt;
  logic signed [AW:0]   pitch_sum, yaw_sum, roll_sum;
  logic signed [AW:0]   pitch_q, yaw_q, roll_q;

  assign busy = 1'b0;

  q2e_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (start && !busy),
    .w_i     (in_quat_w),
    .x_i     (in_quat_x),
    .y_i     (in_quat_y),
    .z_i     (in_quat_z),
    .valid_o (f_valid),
    .rad_o   (f_rad),
    .side_o  (f_side)
  );

  q2e_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (f_valid),
    .rad_i   (f_rad),
    .side_i  (f_side),
    .valid_o (s_valid),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  q2e_cordic u_yaw (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s_valid),
    .tag_i   (1'b0),
    .num_i   (s_side.yn),
    .den_i   (s_side.yd),
    .valid_o (py_valid),
    .tag_o   (y_tag),
    .angle_o (yaw_a)
  );

  q2e_cordic u_pitch (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s_valid),
    .tag_i   (s_side.clamped),
    .num_i   (q2e_pkg::SW'(s_side.s)),
    .den_i   ({{(q2e_pkg::SW-29){1'b0}}, s_root}),
    .valid_o (pp_valid),
    .tag_o   (p_tag),
    .angle_o (pitch_a)
  );

  q2e_cordic u_roll (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s_valid),
    .tag_i   (1'b0),
    .num_i   (s_side.rn),
    .den_i   (s_side.rd),
    .valid_o (pr_valid),
    .tag_o   (r_tag),
    .angle_o (roll_a)
  );

  always_comb begin
    pitch_sum = -(AW+1)'(pitch_a) + (AW+1)'(512);
    yaw_sum   = (AW+1)'(yaw_a) + (AW+1)'(512);
    roll_sum  = (AW+1)'(roll_a) + (AW+1)'(512);
    pitch_q   = pitch_sum >>> 10;
    yaw_q     = yaw_sum >>> 10;
    roll_q    = roll_sum >>> 10;
    if (pitch_q > (AW+1)'(q2e_pkg::PITCH_LIM)) begin
      pitch_nxt = q2e_pkg::PITCH_LIM;
    end else if (pitch_q < -(AW+1)'(q2e_pkg::PITCH_LIM)) begin
      pitch_nxt = -q2e_pkg::PITCH_LIM;
    end else begin
      pitch_nxt = 14'(pitch_q);
    end
    if (yaw_q > (AW+1)'(q2e_pkg::ANGLE_LIM)) begin
      yaw_nxt = q2e_pkg::ANGLE_LIM;
    end else if (yaw_q < -(AW+1)'(q2e_pkg::ANGLE_LIM)) begin
      yaw_nxt = -q2e_pkg::ANGLE_LIM;
    end else begin
      yaw_nxt = 15'(yaw_q);
    end
    if (roll_q > (AW+1)'(q2e_pkg::ANGLE_LIM)) begin
      roll_nxt = q2e_pkg::ANGLE_LIM;
    end else if (roll_q < -(AW+1)'(q2e_pkg::ANGLE_LIM)) begin
      roll_nxt = -q2e_pkg::ANGLE_LIM;
    end else begin
      roll_nxt = 15'(roll_q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= py_valid;
    end
  end

  always_ff @(posedge clk) begin
    pitch_r   <= pitch_nxt;
    yaw_r     <= yaw_nxt;
    roll_r    <= roll_nxt;
    clamped_r <= p_tag;
  end

  assign out_valid        = out_valid_r;
  assign out_pitch_deg    = pitch_r;
  assign out_yaw_deg      = yaw_r;
  assign out_roll_deg     = roll_r;
  assign out_asin_clamped = clamped_r;

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, q2e_pkg::LATENCY))
    else $error("result transfer without matching input transfer");

  a_lanes : assert property (@(posedge clk) disable iff (!rst_n)
    (py_valid == pp_valid) && (py_valid == pr_valid) && !(py_valid && (y_tag || r_tag)))
    else $error("cordic lanes out of step");

  a_pitch_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_deg <= q2e_pkg::PITCH_LIM) &&
                  (out_pitch_deg >= -q2e_pkg::PITCH_LIM))
    else $error("pitch out of range");

endmodule
